@@ hw/rtl/ttr_pkg.sv @@
// Shared types and constants for the timer table with reload.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package ttr_pkg;

   typedef enum logic [2:0] {
      OP_START_AT   = 3'd0,
      OP_START_FREE = 3'd1,
      OP_DESTROY    = 3'd2,
      OP_PAUSE      = 3'd3,
      OP_CONSUME    = 3'd4,
      OP_QPAUSED    = 3'd5,
      OP_EXISTS     = 3'd6,
      OP_ADVANCE    = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_USED  = 3'd1,
      ST_SHORT = 3'd2,
      ST_NONE  = 3'd3,
      ST_FULL  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_DIV,
      S_WRITE,
      S_RESP
   } state_type;

   typedef struct packed {
      logic exec;       // run a single-slot opcode on the latched beat
      logic scan_start; // reset the slot pointer for an advance
      logic scan_next;  // step the slot pointer
      logic div_start;  // load the divider from the current slot
      logic div_step;   // one restoring-division step
      logic wr_slot;    // write back the current slot's advance result
      logic rsp_load;   // show the response beat
   } cmd_type;

   typedef struct packed {
      logic scan_last;  // pointer is at the last slot
      logic need_div;   // current slot is running, wraps and its period is nonzero
      logic div_done;   // divider has finished
   } sts_type;

endpackage

@@ hw/rtl/ttr_ctrl.sv @@
// Controller state machine for the timer table.
// Depends on ttr_pkg.
`timescale 1ns / 1ps
module ttr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  ttr_pkg::op_type  op,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output ttr_pkg::cmd_type cmd,
   input  ttr_pkg::sts_type sts
);

   ttr_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == ttr_pkg::S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ttr_pkg::S_IDLE:
            if (req_tvalid && req_tready) begin
               state_in = ttr_pkg::S_EXEC;
            end
         ttr_pkg::S_EXEC:
            state_in = (op == ttr_pkg::OP_ADVANCE) ? ttr_pkg::S_SCAN : ttr_pkg::S_RESP;
         ttr_pkg::S_SCAN:
            state_in = sts.need_div ? ttr_pkg::S_DIV : ttr_pkg::S_WRITE;
         ttr_pkg::S_DIV:
            if (sts.div_done) begin
               state_in = ttr_pkg::S_WRITE;
            end
         ttr_pkg::S_WRITE:
            state_in = sts.scan_last ? ttr_pkg::S_RESP : ttr_pkg::S_SCAN;
         ttr_pkg::S_RESP:
            state_in = ttr_pkg::S_IDLE;
         default:
            state_in = ttr_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ttr_pkg::S_EXEC: begin
            cmd.exec       = (op != ttr_pkg::OP_ADVANCE);
            cmd.scan_start = (op == ttr_pkg::OP_ADVANCE);
         end
         ttr_pkg::S_SCAN:
            cmd.div_start = sts.need_div;
         ttr_pkg::S_DIV:
            cmd.div_step = !sts.div_done;
         ttr_pkg::S_WRITE: begin
            cmd.wr_slot   = 1'b1;
            cmd.scan_next = !sts.scan_last;
         end
         ttr_pkg::S_RESP:
            cmd.rsp_load = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttr_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ttr_pkg::S_IDLE)
      else $error("ready outside idle");
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ttr_pkg::S_EXEC)
      else $error("accept did not start work");
   a_resp_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff)
      else $error("response lost");
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ttr_pkg::S_DIV && sts.div_done |=> state_ff == ttr_pkg::S_WRITE)
      else $error("divider exit");

endmodule

@@ hw/rtl/ttr_datapath.sv @@
// Datapath of the timer table: slot registers, shared divider, response.
// Depends on ttr_pkg.
`timescale 1ns / 1ps
module ttr_datapath #(
   parameter int NUM_TIMERS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_accept,
   input  logic [79:0]      req_tdata,
   input  logic             csr_we,
   input  logic [31:0]      csr_wdata,
   input  ttr_pkg::cmd_type cmd,
   output ttr_pkg::sts_type sts,
   output ttr_pkg::op_type  op,
   output logic [7:0]       rsp_tdata
);

   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   // Latched request beat and the minimum interval.
   logic [2:0]  op_ff;
   logic [3:0]  id_ff;
   logic [31:0] ivl_ff;
   logic        once_ff, pv_ff;
   logic [30:0] dt_ff;
   logic [31:0] min_ff;

   logic [NUM_TIMERS-1:0] used_ff, paused_ff, ticked_ff, oneshot_ff;
   logic [31:0] period_ff [NUM_TIMERS];
   logic [31:0] remain_ff [NUM_TIMERS];

   logic [IW-1:0] ptr_ff;
   logic [31:0]   rem_ff;   // partial remainder
   logic [31:0]   quo_ff;   // dividend bits left to shift in
   logic [5:0]    cnt_ff;

   logic [2:0]  status_ff;
   logic        flag_ff;
   logic [3:0]  aid_ff;

   // Single-slot opcode result, held until the response beat.
   logic [2:0] st_ff;
   logic       fl_ff;
   logic [3:0] as_ff;

   assign op = ttr_pkg::op_type'(op_ff);
   assign rsp_tdata = {aid_ff, flag_ff, status_ff};

   // Addressed slot.
   logic          id_ok, live;
   logic [IW-1:0] idx;
   assign id_ok = ({28'd0, id_ff} < 32'(NUM_TIMERS));
   assign idx   = IW'(id_ff);
   assign live  = id_ok && used_ff[idx];

   // Lowest free slot.
   logic          free_found;
   logic [IW-1:0] free_idx;
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IW'(i);
         end
      end
   end

   // Advance scan of the current slot.
   logic [31:0] cur_r, cur_p, dt32, diff;
   logic        active, wraps;
   assign cur_r  = remain_ff[ptr_ff];
   assign cur_p  = period_ff[ptr_ff];
   assign dt32   = {1'b0, dt_ff};
   assign active = used_ff[ptr_ff] && !paused_ff[ptr_ff];
   assign wraps  = cur_r < dt32;
   assign diff   = dt32 - cur_r;
   assign sts.need_div  = active && wraps && (cur_p != 32'd0);
   assign sts.scan_last = (32'(ptr_ff) == 32'(NUM_TIMERS - 1));
   assign sts.div_done  = (cnt_ff == 6'd32);

   // One restoring step.
   logic [32:0] shifted, trial;
   assign shifted = {rem_ff, quo_ff[31]};
   assign trial   = shifted - {1'b0, cur_p};

   logic [31:0] new_rem;
   always_comb begin
      if (!wraps) begin
         new_rem = cur_r - dt32;
      end else if (cur_p == 32'd0 || rem_ff == 32'd0) begin
         new_rem = 32'd0;
      end else begin
         new_rem = cur_p - rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff   <= req_tdata[2:0];
         id_ff   <= req_tdata[6:3];
         ivl_ff  <= req_tdata[38:7];
         once_ff <= req_tdata[39];
         pv_ff   <= req_tdata[40];
         dt_ff   <= req_tdata[71:41];
      end
      if (cmd.scan_start) begin
         ptr_ff <= '0;
      end else if (cmd.scan_next) begin
         ptr_ff <= ptr_ff + IW'(1);
      end
      if (cmd.div_start) begin
         rem_ff <= 32'd0;
         quo_ff <= diff;
         cnt_ff <= 6'd0;
      end else if (cmd.div_step) begin
         rem_ff <= trial[32] ? shifted[31:0] : trial[31:0];
         quo_ff <= {quo_ff[30:0], 1'b0};
         cnt_ff <= cnt_ff + 6'd1;
      end
      if (cmd.exec) begin
         if ((op == ttr_pkg::OP_START_AT && live == 1'b0 && id_ok && ivl_ff >= min_ff)
             || (op == ttr_pkg::OP_START_FREE && free_found && ivl_ff >= min_ff)) begin
            period_ff[(op == ttr_pkg::OP_START_AT) ? idx : free_idx] <= ivl_ff;
            remain_ff[(op == ttr_pkg::OP_START_AT) ? idx : free_idx] <= ivl_ff;
         end
      end
      if (cmd.wr_slot && active) begin
         remain_ff[ptr_ff] <= new_rem;
      end
      if (cmd.rsp_load) begin
         status_ff <= st_ff;
         flag_ff   <= fl_ff;
         aid_ff    <= as_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff     <= 32'd1;
         used_ff    <= '0;
         paused_ff  <= '0;
         ticked_ff  <= '0;
         oneshot_ff <= '0;
         st_ff      <= ttr_pkg::ST_OK;
         fl_ff      <= 1'b0;
         as_ff      <= 4'd0;
      end else begin
         if (csr_we) begin
            min_ff <= csr_wdata;
         end
         if (cmd.scan_start) begin
            st_ff <= ttr_pkg::ST_OK;
            fl_ff <= 1'b0;
            as_ff <= 4'd0;
         end
         if (cmd.wr_slot && active && wraps) begin
            ticked_ff[ptr_ff] <= 1'b1;
         end
         if (cmd.exec) begin
            st_ff <= ttr_pkg::ST_OK;
            fl_ff <= 1'b0;
            as_ff <= 4'd0;
            unique case (op)
               ttr_pkg::OP_START_AT: begin
                  if (!id_ok) begin
                     st_ff <= ttr_pkg::ST_NONE;
                  end else if (used_ff[idx]) begin
                     st_ff <= ttr_pkg::ST_USED;
                  end else if (ivl_ff < min_ff) begin
                     st_ff <= ttr_pkg::ST_SHORT;
                  end else begin
                     used_ff[idx]    <= 1'b1;
                     paused_ff[idx]  <= 1'b0;
                     ticked_ff[idx]  <= 1'b0;
                     oneshot_ff[idx] <= once_ff;
                  end
               end
               ttr_pkg::OP_START_FREE: begin
                  if (!free_found) begin
                     st_ff <= ttr_pkg::ST_FULL;
                  end else if (ivl_ff < min_ff) begin
                     st_ff <= ttr_pkg::ST_SHORT;
                  end else begin
                     used_ff[free_idx]    <= 1'b1;
                     paused_ff[free_idx]  <= 1'b0;
                     ticked_ff[free_idx]  <= 1'b0;
                     oneshot_ff[free_idx] <= once_ff;
                     as_ff <= 4'(free_idx);
                  end
               end
               ttr_pkg::OP_DESTROY: begin
                  if (!live) begin
                     st_ff <= ttr_pkg::ST_NONE;
                  end else begin
                     used_ff[idx]    <= 1'b0;
                     paused_ff[idx]  <= 1'b0;
                     ticked_ff[idx]  <= 1'b0;
                     oneshot_ff[idx] <= 1'b0;
                  end
               end
               ttr_pkg::OP_PAUSE: begin
                  if (!live) begin
                     st_ff <= ttr_pkg::ST_NONE;
                  end else begin
                     paused_ff[idx] <= pv_ff;
                  end
               end
               ttr_pkg::OP_CONSUME: begin
                  if (!live) begin
                     st_ff <= ttr_pkg::ST_NONE;
                  end else if (!paused_ff[idx] && ticked_ff[idx]) begin
                     ticked_ff[idx] <= 1'b0;
                     fl_ff <= 1'b1;
                     if (oneshot_ff[idx]) begin
                        used_ff[idx]    <= 1'b0;
                        paused_ff[idx]  <= 1'b0;
                        oneshot_ff[idx] <= 1'b0;
                     end
                  end
               end
               ttr_pkg::OP_QPAUSED: begin
                  if (!live) begin
                     st_ff <= ttr_pkg::ST_NONE;
                  end else begin
                     fl_ff <= paused_ff[idx];
                  end
               end
               ttr_pkg::OP_EXISTS:
                  fl_ff <= live;
               default: ;
            endcase
         end
      end
   end

   a_paused_used: assert property (@(posedge clock) disable iff (reset)
      (paused_ff & ~used_ff) == '0)
      else $error("paused mark on a free slot");
   a_ticked_used: assert property (@(posedge clock) disable iff (reset)
      (ticked_ff & ~used_ff) == '0)
      else $error("ticked mark on a free slot");
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> cnt_ff < 6'd32)
      else $error("divider overrun");

endmodule

@@ hw/rtl/timer_table_with_reload.sv @@
// Top level of the timer table with reload: stream ports, controller, datapath.
// Depends on ttr_pkg, ttr_ctrl and ttr_datapath.
// Single-slot opcodes pass through an execute state and a response state.
// An advance visits every slot; a running slot that wraps with a nonzero period
// also passes through the shared restoring divider, one bit per cycle, before
// its write-back.
// One beat is in flight at a time; the next is taken once the response is out.
// Reset is synchronous and active high; it frees every slot and sets
// min_interval to 1. Period and remaining time are not reset.
`timescale 1ns / 1ps
module timer_table_with_reload #(
   parameter int NUM_TIMERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[2:0], timer_id[6:3], interval[38:7], one_shot[39], pause_value[40],
   // elapsed[71:41], zero fill [79:72]
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0], flag[3], assigned_id[7:4]
   output logic [7:0]  rsp_tdata,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   // Commands and status between the controller and the datapath.
   ttr_pkg::cmd_type cmd;
   ttr_pkg::sts_type sts;
   ttr_pkg::op_type  op;

   // The controller sequences each beat: a single execute state for slot opcodes,
   // or a walk over all slots for an advance.
   ttr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .op         (op),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // The datapath holds the slots, the divider that computes the reload
   // remainder, and the response register.
   ttr_datapath #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_tvalid && req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .op         (op),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
